[hw/rtl/arpc_pkg.sv]
// Shared types and codes for the ARP cache table.
`timescale 1ns / 1ps

package arpc_pkg;

  localparam int KEY_W = 32;
  localparam int MAC_W = 48;
  localparam int CNT_OUT_W = 7;
  localparam int IN_TDATA_W = 88;
  localparam int OUT_TDATA_W = 64;

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [MAC_W-1:0] mac;
  } arpc_entry_t;

  typedef struct packed {
    logic        shift_en;
    logic        wr_en;
    arpc_entry_t wr_data;
  } arpc_cmd_t;

endpackage

[hw/rtl/arp_cache_table_unit.sv]
// Top level of the ARP cache table: a row of slot cells and the sequencer that drives it.
`timescale 1ns / 1ps

// Each operation passes the scan, commit and done states before the next input beat is
// taken: the scan turns the whole cell row once past the compare at its head, the commit
// makes any removal and append as a single shift and write across the row, and the done
// state loads the result register and returns to idle once the output register is free.
// The result beat waits in its own register, so a new input beat is taken while it is held.
// Entries stay packed in insertion order; an update with the table full and no matching
// key is refused with status set.
module arp_cache_table_unit
  import arpc_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // opcode[1:0], ip_key[33:2], mac_in[81:34]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // hit[0], mac_out[48:1], status[49], entry_count[56:50]
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  arpc_cmd_t           cmd;
  logic [IW-1:0]       shift_from;
  logic [IW-1:0]       wr_idx;
  arpc_entry_t         ent [TABLE_DEPTH];

  arpc_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .IW    (IW),
    .CW    (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .head       (ent[0]),
    .cmd        (cmd),
    .shift_from (shift_from),
    .wr_idx     (wr_idx)
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam int NXT = (i + 1) % TABLE_DEPTH;
    arpc_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .shift_from (shift_from),
      .wr_idx     (wr_idx),
      .nbr_in     (ent[NXT]),
      .ent_out    (ent[i])
    );
  end

endmodule

[hw/rtl/arpc_cell.sv]
// One table slot: holds a key and MAC pair and takes its neighbor's pair on a shift.
`timescale 1ns / 1ps

module arpc_cell
  import arpc_pkg::*;
#(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic        clk,
  input  arpc_cmd_t   cmd,
  input  logic [IW-1:0] shift_from,
  input  logic [IW-1:0] wr_idx,
  input  arpc_entry_t nbr_in,
  output arpc_entry_t ent_out
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  arpc_entry_t ent_r;

  // A write at this slot takes priority over the shift that closes a gap.
  always_ff @(posedge clk) begin
    if (cmd.wr_en && (wr_idx == MY_IDX)) begin
      ent_r <= cmd.wr_data;
    end else if (cmd.shift_en && (MY_IDX >= shift_from)) begin
      ent_r <= nbr_in;
    end
  end

  assign ent_out = ent_r;

endmodule

[hw/rtl/arpc_ctrl.sv]
// Sequencer that scans the rotating cell row, commits the operation and drives the result beat.
`timescale 1ns / 1ps

module arpc_ctrl
  import arpc_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int IW    = 6,
  parameter int CW    = 7
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  arpc_entry_t            head,
  output arpc_cmd_t              cmd,
  output logic [IW-1:0]          shift_from,
  output logic [IW-1:0]          wr_idx
);

  localparam int EW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_COMMIT = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t               state_r;
  logic [1:0]           op_r;
  logic [KEY_W-1:0]     key_r;
  logic [MAC_W-1:0]     mac_r;
  logic [IW-1:0]        k_r;
  logic                 found_r;
  logic [IW-1:0]        pos_r;
  logic [MAC_W-1:0]     lmac_r;
  logic [CW-1:0]        fill_r;
  logic [CW-1:0]        fill_nxt;
  logic                 refuse;
  logic                 scan_match;
  logic                 res_hit_r;
  logic [MAC_W-1:0]     res_mac_r;
  logic                 res_status_r;
  logic                 out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [EW-1:0]        cnt_ext;
  logic                 out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_free   = !out_tvalid_r || out_tready;

  // The row turns by one slot each scan cycle, so after k turns the head holds slot k.
  assign scan_match = (state_r == ST_SCAN) && !found_r && (CW'(k_r) < fill_r) &&
                      (head.key == key_r);

  always_comb begin
    cmd.shift_en     = 1'b0;
    cmd.wr_en        = 1'b0;
    cmd.wr_data.key  = key_r;
    cmd.wr_data.mac  = mac_r;
    shift_from       = '0;
    wr_idx           = '0;
    fill_nxt         = fill_r;
    refuse           = 1'b0;
    if (state_r == ST_SCAN) begin
      cmd.shift_en = 1'b1;
    end else if (state_r == ST_COMMIT) begin
      case (op_r)
        OP_UPDATE: begin
          if (found_r) begin
            cmd.shift_en = 1'b1;
            shift_from   = pos_r;
            cmd.wr_en    = 1'b1;
            wr_idx       = IW'(fill_r - 1'b1);
          end else if (fill_r != FULL_CNT) begin
            cmd.wr_en = 1'b1;
            wr_idx    = IW'(fill_r);
            fill_nxt  = fill_r + 1'b1;
          end else begin
            refuse = 1'b1;
          end
        end
        OP_DELETE: begin
          if (found_r) begin
            cmd.shift_en = 1'b1;
            shift_from   = pos_r;
            fill_nxt     = fill_r - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign cnt_ext = EW'(fill_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if ((state_r == ST_DONE) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (k_r == LAST_IDX) begin
            state_r <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          fill_r  <= fill_nxt;
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        op_r    <= in_tdata[1:0];
        key_r   <= in_tdata[33:2];
        mac_r   <= in_tdata[81:34];
        k_r     <= '0;
        found_r <= 1'b0;
      end
      ST_SCAN: begin
        k_r <= k_r + 1'b1;
        if (scan_match) begin
          found_r <= 1'b1;
          pos_r   <= k_r;
          lmac_r  <= head.mac;
        end
      end
      ST_COMMIT: begin
        res_hit_r    <= found_r && ((op_r == OP_LOOKUP) || (op_r == OP_DELETE));
        res_mac_r    <= (found_r && (op_r == OP_LOOKUP)) ? lmac_r : '0;
        res_status_r <= refuse;
      end
      ST_DONE: begin
        if (out_free) begin
          out_tdata_r <= {7'd0, cnt_ext[CNT_OUT_W-1:0], res_status_r, res_mac_r, res_hit_r};
        end
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("entry count exceeds table depth");

  a_refuse_keeps : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMMIT) && refuse |=> fill_r == $past(fill_r))
    else $error("refused update changed the entry count");

  a_out_from_done : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ST_DONE))
    else $error("result beat raised outside the done state");

  a_scan_no_write : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !cmd.wr_en && (shift_from == '0))
    else $error("scan must rotate the whole row without writes");
`endif

endmodule
